// ===== rtl/tesp_pkg.sv =====
// ----------------------------------------------------------------------------
// tesp_pkg
// Shared types, codes and constants of the terminal escape sequence parser.
// ----------------------------------------------------------------------------
package tesp_pkg;

    // Default sizes of the parameter and title stores
    localparam int MAX_PARAMS_DEF = 16;
    localparam int OSC_BYTES_DEF  = 32;

    // Queue depths (powers of two)
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;

    // Width of the parameter count carried in a command (covers counts up to 127)
    localparam int CNT_W = 7;

    // Marker of a parameter that had no digits
    localparam logic [16:0] MISSING = 17'h10000;

    // Stream bytes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UJ    = 8'h4A;
    localparam logic [7:0] CH_UK    = 8'h4B;
    localparam logic [7:0] CH_LF_F  = 8'h66;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_LM    = 8'h6D;
    localparam logic [7:0] CH_LR    = 8'h72;

    // Action codes
    localparam logic [4:0] ACT_PRINT     = 5'd0;
    localparam logic [4:0] ACT_NEWLINE   = 5'd1;
    localparam logic [4:0] ACT_CR        = 5'd2;
    localparam logic [4:0] ACT_BS        = 5'd3;
    localparam logic [4:0] ACT_TAB       = 5'd4;
    localparam logic [4:0] ACT_UP        = 5'd5;
    localparam logic [4:0] ACT_DOWN      = 5'd6;
    localparam logic [4:0] ACT_FWD       = 5'd7;
    localparam logic [4:0] ACT_BACK      = 5'd8;
    localparam logic [4:0] ACT_COLUMN    = 5'd9;
    localparam logic [4:0] ACT_POS       = 5'd10;
    localparam logic [4:0] ACT_ERASE_EOS = 5'd11;
    localparam logic [4:0] ACT_ERASE_SCR = 5'd12;
    localparam logic [4:0] ACT_ERASE_EOL = 5'd13;
    localparam logic [4:0] ACT_SCROLL    = 5'd16;
    localparam logic [4:0] ACT_SGR_RESET = 5'd17;
    localparam logic [4:0] ACT_ATTR      = 5'd18;
    localparam logic [4:0] ACT_FG_DEF    = 5'd19;
    localparam logic [4:0] ACT_BG_DEF    = 5'd20;
    localparam logic [4:0] ACT_FG_PAL    = 5'd21;
    localparam logic [4:0] ACT_FG_RGB    = 5'd23;
    localparam logic [4:0] ACT_CURSOR    = 5'd25;
    localparam logic [4:0] ACT_ALT_SCR   = 5'd26;
    localparam logic [4:0] ACT_TITLE     = 5'd27;
    localparam logic [4:0] ACT_TITLE_CH  = 5'd28;
    localparam logic [4:0] ACT_MAX       = 5'd28;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_SIMPLE,
        CMD_CSI,
        CMD_TITLE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [4:0]        act;   // simple action code
        logic [15:0]       data;  // printed byte, CSI final byte or title length
        logic              priv;  // private '?' sequence
        logic [CNT_W-1:0]  cnt;   // parameter count
    } t_cmd;

    typedef struct packed {
        logic [4:0]  act;
        logic [15:0] value;
        logic [15:0] arg_a;
        logic [7:0]  arg_b;
        logic        last;
    } t_result;

endpackage

// ===== rtl/tesp_fifo.sv =====
// ----------------------------------------------------------------------------
// tesp_fifo
// Small synchronous queue with registered storage.
// ----------------------------------------------------------------------------
module tesp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store item
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/tesp_front.sv =====
// ----------------------------------------------------------------------------
// tesp_front
// Byte classifier: mode tracking, parameter and title capture, and command
// issue toward the back end.
// ----------------------------------------------------------------------------
module tesp_front #(
    parameter int MAX_PARAMS = 16,
    parameter int OSC_BYTES  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [7:0]                      i_byte_in,
    output logic                            o_full,
    output tesp_pkg::t_cmd                  o_cmd,
    output logic                            o_cmd_push,
    input  logic                            i_cmdq_full,
    input  logic                            i_done,
    input  logic [$clog2(MAX_PARAMS)-1:0]   i_prd_idx,
    output logic [16:0]                     o_prd_data,
    input  logic [$clog2(OSC_BYTES)-1:0]    i_ord_idx,
    output logic [7:0]                      o_ord_data
);
    import tesp_pkg::*;

    localparam int PIW = $clog2(MAX_PARAMS);
    localparam int PCW = $clog2(MAX_PARAMS + 1);
    localparam int OIW = $clog2(OSC_BYTES);
    localparam int OLW = $clog2(OSC_BYTES + 1);

    typedef enum logic [2:0] {
        M_NORMAL,
        M_ESCAPE,
        M_CSI,
        M_OSC,
        M_OSCESC
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [PCW-1:0] r_pcnt, n_pcnt;
    logic [16:0]    r_cur, n_cur;
    logic           r_priv, n_priv;
    logic [OLW-1:0] r_olen, n_olen;
    logic           r_lock, n_lock;
    logic [16:0]    r_pstore [MAX_PARAMS];
    logic [7:0]     r_obuf [OSC_BYTES];

    logic           accept;
    logic           pwe;
    logic           owe;
    logic [15:0]    dval;
    logic [19:0]    prod;
    logic           is_digit;
    logic           room;
    logic [PCW-1:0] cnt_closed;

    assign o_full     = i_cmdq_full || r_lock;
    assign accept     = i_push && !o_full;
    assign o_prd_data = r_pstore[i_prd_idx];
    assign o_ord_data = r_obuf[i_ord_idx];

    assign is_digit   = (i_byte_in >= CH_ZERO) && (i_byte_in <= CH_NINE);
    assign dval       = r_cur[16] ? 16'd0 : r_cur[15:0];
    assign prod       = {1'b0, dval, 3'b000} + {3'b000, dval, 1'b0}
                        + {16'd0, i_byte_in[3:0]};
    assign room       = (r_pcnt < PCW'(MAX_PARAMS));
    assign cnt_closed = room ? r_pcnt + 1'b1 : r_pcnt;

    // Classify the byte and issue commands
    always_comb begin
        n_mode     = r_mode;
        n_pcnt     = r_pcnt;
        n_cur      = r_cur;
        n_priv     = r_priv;
        n_olen     = r_olen;
        n_lock     = r_lock;
        pwe        = 1'b0;
        owe        = 1'b0;
        o_cmd_push = 1'b0;
        o_cmd      = '{kind: CMD_SIMPLE, act: ACT_PRINT, data: {8'd0, i_byte_in},
                       priv: r_priv, cnt: CNT_W'(cnt_closed)};
        if (i_done) begin
            n_lock = 1'b0;
        end
        if (accept) begin
            case (r_mode)
                M_NORMAL: begin
                    o_cmd_push = 1'b1;
                    if (i_byte_in == CH_ESC) begin
                        o_cmd_push = 1'b0;
                        n_mode     = M_ESCAPE;
                    end else if (i_byte_in == CH_LF) begin
                        o_cmd.act  = ACT_NEWLINE;
                        o_cmd.data = '0;
                    end else if (i_byte_in == CH_CR) begin
                        o_cmd.act  = ACT_CR;
                        o_cmd.data = '0;
                    end else if (i_byte_in == CH_BS) begin
                        o_cmd.act  = ACT_BS;
                        o_cmd.data = '0;
                    end else if (i_byte_in == CH_TAB) begin
                        o_cmd.act  = ACT_TAB;
                        o_cmd.data = '0;
                    end else if (i_byte_in < CH_SPACE || i_byte_in == CH_DEL) begin
                        o_cmd_push = 1'b0;
                    end
                end
                M_ESCAPE: begin
                    if (i_byte_in == CH_LBRK) begin
                        n_mode = M_CSI;
                        n_pcnt = '0;
                        n_cur  = MISSING;
                        n_priv = 1'b0;
                    end else if (i_byte_in == CH_RBRK) begin
                        n_mode = M_OSC;
                        n_olen = '0;
                    end else begin
                        n_mode = M_NORMAL;
                    end
                end
                M_CSI: begin
                    if (i_byte_in == CH_QUEST && r_pcnt == '0 && r_cur == MISSING) begin
                        n_priv = 1'b1;
                    end else if (is_digit) begin
                        n_cur = (prod > 20'd65535) ? 17'h0FFFF : {1'b0, prod[15:0]};
                    end else begin
                        // Close the open parameter
                        pwe    = room;
                        n_pcnt = cnt_closed;
                        n_cur  = MISSING;
                        if (i_byte_in != CH_SEMI) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = CMD_CSI;
                            n_lock     = 1'b1;
                            n_pcnt     = '0;
                            n_priv     = 1'b0;
                            n_mode     = M_NORMAL;
                        end
                    end
                end
                M_OSC: begin
                    if (i_byte_in == CH_BEL) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = CMD_TITLE;
                        o_cmd.data = 16'(r_olen);
                        n_lock     = 1'b1;
                        n_mode     = M_NORMAL;
                    end else if (i_byte_in == CH_ESC) begin
                        n_mode = M_OSCESC;
                    end else if (r_olen < OLW'(OSC_BYTES)) begin
                        owe    = 1'b1;
                        n_olen = r_olen + 1'b1;
                    end
                end
                M_OSCESC: begin
                    if (i_byte_in == CH_BSL) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = CMD_TITLE;
                        o_cmd.data = 16'(r_olen);
                        n_lock     = 1'b1;
                    end
                    n_mode = M_NORMAL;
                end
                default: begin
                    n_mode = M_NORMAL;
                end
            endcase
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_pcnt <= '0;
            r_cur  <= MISSING;
            r_priv <= 1'b0;
            r_olen <= '0;
            r_lock <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pcnt <= n_pcnt;
            r_cur  <= n_cur;
            r_priv <= n_priv;
            r_olen <= n_olen;
            r_lock <= n_lock;
        end
    end

    // Write parameter and title stores
    always_ff @(posedge i_clk) begin
        if (pwe) begin
            r_pstore[r_pcnt[PIW-1:0]] <= r_cur;
        end
        if (owe) begin
            r_obuf[r_olen[OIW-1:0]] <= i_byte_in;
        end
    end

endmodule

// ===== rtl/tesp_back.sv =====
// ----------------------------------------------------------------------------
// tesp_back
// Command executor: walks stored parameters and title bytes and produces
// actions one command at a time, tagging the final action of each byte.
// ----------------------------------------------------------------------------
module tesp_back #(
    parameter int MAX_PARAMS = 16,
    parameter int OSC_BYTES  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tesp_pkg::t_cmd                  i_cmd,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_pop,
    input  logic [15:0]                     i_screen_rows,
    output logic [$clog2(MAX_PARAMS)-1:0]   o_prd_idx,
    input  logic [16:0]                     i_prd_data,
    output logic [$clog2(OSC_BYTES)-1:0]    o_ord_idx,
    input  logic [7:0]                      i_ord_data,
    output tesp_pkg::t_result               o_res,
    output logic                            o_res_push,
    input  logic                            i_res_full,
    output logic                            o_done
);
    import tesp_pkg::*;

    localparam int PIW = $clog2(MAX_PARAMS);
    localparam int OIW = $clog2(OSC_BYTES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_C0,
        S_C1,
        S_SGR,
        S_SGR_M,
        S_SGR_IDX,
        S_SGR_R,
        S_SGR_G,
        S_SGR_B,
        S_PRIV,
        S_T_SCAN,
        S_T_EMIT,
        S_FLUSH
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_i, n_i;
    logic [16:0]      r_a0, n_a0;
    logic             r_base, n_base;
    logic [7:0]       r_r, n_r;
    logic [7:0]       r_g, n_g;
    logic [9:0]       r_sel, n_sel;
    t_result          r_pend, n_pend;
    logic             r_pend_v, n_pend_v;

    logic             emit;
    t_result          e_res;
    logic             go;
    logic [CNT_W:0]   i_ext;
    logic [CNT_W:0]   cnt_ext;
    logic             p_valid;
    logic [16:0]      praw;
    logic [15:0]      az;
    logic [15:0]      ar0;
    logic [15:0]      ar1;
    logic [15:0]      bot;
    logic [7:0]       fin;
    logic [7:0]       ch;
    logic [13:0]      sel_next;

    // Value or default when missing or zero
    function automatic logic [15:0] arg_or(input logic [16:0] raw, input logic [15:0] def);
        logic [15:0] res;
        res = (raw[16] || raw == 17'd0) ? def : raw[15:0];
        return res;
    endfunction

    function automatic logic [7:0] clamp255(input logic [15:0] v);
        logic [7:0] res;
        res = (v > 16'd255) ? 8'd255 : v[7:0];
        return res;
    endfunction

    assign o_prd_idx = r_i[PIW-1:0];
    assign o_ord_idx = r_i[OIW-1:0];
    assign i_ext     = {1'b0, r_i};
    assign cnt_ext   = {1'b0, r_cmd.cnt};
    assign p_valid   = (r_i < r_cmd.cnt);
    assign praw      = p_valid ? i_prd_data : MISSING;
    assign az        = praw[16] ? 16'd0 : praw[15:0];
    assign ar0       = arg_or(r_a0, 16'd1);
    assign ar1       = arg_or(praw, 16'd1);
    assign bot       = arg_or(praw, i_screen_rows);
    assign fin       = r_cmd.data[7:0];
    assign ch        = i_ord_data;
    assign sel_next  = {r_sel, 3'b000} + {3'b000, r_sel, 1'b0} + {10'd0, ch[3:0]};

    // Sequence one command
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_i      = r_i;
        n_a0     = r_a0;
        n_base   = r_base;
        n_r      = r_r;
        n_g      = r_g;
        n_sel    = r_sel;
        emit     = 1'b0;
        e_res    = '{act: ACT_SGR_RESET, value: '0, arg_a: '0, arg_b: '0, last: 1'b0};
        go       = 1'b1;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_pend;
        o_done     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    n_i   = '0;
                    n_sel = '0;
                    case (i_cmd.kind)
                        CMD_SIMPLE: begin
                            go         = !i_res_full;
                            o_res_push = 1'b1;
                            o_res      = '{act: i_cmd.act, value: i_cmd.data, arg_a: '0,
                                           arg_b: '0, last: 1'b1};
                        end
                        CMD_CSI: begin
                            if (i_cmd.priv) begin
                                n_state = (i_cmd.data[7:0] == CH_LH ||
                                           i_cmd.data[7:0] == CH_LL) ? S_PRIV : S_FLUSH;
                            end else if (i_cmd.data[7:0] == CH_LM) begin
                                n_state = S_SGR;
                            end else begin
                                n_state = S_C0;
                            end
                        end
                        CMD_TITLE: begin
                            n_state = S_T_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                    o_cmd_pop = go;
                end
            end
            S_C0: begin
                n_a0    = praw;
                n_i     = r_i + 1'b1;
                n_state = S_C1;
            end
            S_C1: begin
                n_state = S_FLUSH;
                emit    = 1'b1;
                case (fin)
                    CH_UA: begin
                        e_res.act   = ACT_UP;
                        e_res.value = ar0;
                    end
                    CH_UB: begin
                        e_res.act   = ACT_DOWN;
                        e_res.value = ar0;
                    end
                    CH_UC: begin
                        e_res.act   = ACT_FWD;
                        e_res.value = ar0;
                    end
                    CH_UD: begin
                        e_res.act   = ACT_BACK;
                        e_res.value = ar0;
                    end
                    CH_UG: begin
                        e_res.act   = ACT_COLUMN;
                        e_res.value = ar0 - 1'b1;
                    end
                    CH_UH, CH_LF_F: begin
                        e_res.act   = ACT_POS;
                        e_res.value = ar0 - 1'b1;
                        e_res.arg_a = ar1 - 1'b1;
                    end
                    CH_UJ: begin
                        if (r_a0[16] || r_a0 == 17'd0) begin
                            e_res.act = ACT_ERASE_EOS;
                        end else if (r_a0 == 17'd2) begin
                            e_res.act = ACT_ERASE_SCR;
                        end else begin
                            emit = 1'b0;
                        end
                    end
                    CH_UK: begin
                        if (r_a0[16]) begin
                            e_res.act = ACT_ERASE_EOL;
                        end else if (r_a0 <= 17'd2) begin
                            e_res.act = ACT_ERASE_EOL + r_a0[4:0];
                        end else begin
                            emit = 1'b0;
                        end
                    end
                    CH_LR: begin
                        e_res.act   = ACT_SCROLL;
                        e_res.value = ar0 - 1'b1;
                        e_res.arg_a = (bot == 16'd0) ? 16'd0 : bot - 1'b1;
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
            S_SGR: begin
                if (!p_valid) begin
                    n_state = S_FLUSH;
                end else begin
                    n_i  = r_i + 1'b1;
                    emit = 1'b1;
                    if (az == 16'd0) begin
                        e_res.act = ACT_SGR_RESET;
                    end else if (az == 16'd1 || az == 16'd3 || az == 16'd4 ||
                                 az == 16'd7 || az == 16'd9) begin
                        e_res.act   = ACT_ATTR;
                        e_res.value = az;
                        e_res.arg_a = 16'd1;
                    end else if (az == 16'd22 || az == 16'd23 || az == 16'd24 ||
                                 az == 16'd27 || az == 16'd29) begin
                        e_res.act   = ACT_ATTR;
                        e_res.value = az - 16'd20;
                    end else if (az == 16'd39) begin
                        e_res.act = ACT_FG_DEF;
                    end else if (az == 16'd49) begin
                        e_res.act = ACT_BG_DEF;
                    end else if (az == 16'd38 || az == 16'd48) begin
                        emit   = 1'b0;
                        n_base = (az == 16'd48);
                        if (i_ext + 1'b1 < cnt_ext) begin
                            n_state = S_SGR_M;
                        end
                    end else if (az >= 16'd30 && az <= 16'd37) begin
                        e_res.act   = ACT_FG_PAL;
                        e_res.value = az - 16'd30;
                    end else if (az >= 16'd90 && az <= 16'd97) begin
                        e_res.act   = ACT_FG_PAL;
                        e_res.value = az - 16'd82;
                    end else if (az >= 16'd40 && az <= 16'd47) begin
                        e_res.act   = ACT_FG_PAL + 5'd1;
                        e_res.value = az - 16'd40;
                    end else if (az >= 16'd100 && az <= 16'd107) begin
                        e_res.act   = ACT_FG_PAL + 5'd1;
                        e_res.value = az - 16'd92;
                    end else begin
                        emit = 1'b0;
                    end
                end
            end
            S_SGR_M: begin
                if (az == 16'd5 && i_ext + 1'b1 < cnt_ext) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SGR_IDX;
                end else if (az == 16'd2 && i_ext + 2'd3 < cnt_ext) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SGR_R;
                end else begin
                    n_state = S_SGR;
                end
            end
            S_SGR_IDX: begin
                emit        = 1'b1;
                e_res.act   = ACT_FG_PAL + {4'd0, r_base};
                e_res.value = az;
                n_i         = r_i + 1'b1;
                n_state     = S_SGR;
            end
            S_SGR_R: begin
                n_r     = clamp255(az);
                n_i     = r_i + 1'b1;
                n_state = S_SGR_G;
            end
            S_SGR_G: begin
                n_g     = clamp255(az);
                n_i     = r_i + 1'b1;
                n_state = S_SGR_B;
            end
            S_SGR_B: begin
                emit        = 1'b1;
                e_res.act   = ACT_FG_RGB + {4'd0, r_base};
                e_res.value = {8'd0, r_r};
                e_res.arg_a = {8'd0, r_g};
                e_res.arg_b = clamp255(az);
                n_i         = r_i + 1'b1;
                n_state     = S_SGR;
            end
            S_PRIV: begin
                if (!p_valid) begin
                    n_state = S_FLUSH;
                end else begin
                    n_i         = r_i + 1'b1;
                    e_res.value = {15'd0, fin == CH_LH};
                    if (praw == 17'd1049) begin
                        emit      = 1'b1;
                        e_res.act = ACT_ALT_SCR;
                    end else if (praw == 17'd25) begin
                        emit      = 1'b1;
                        e_res.act = ACT_CURSOR;
                    end
                end
            end
            S_T_SCAN: begin
                if (16'(r_i) >= r_cmd.data) begin
                    n_state = S_FLUSH;
                end else if (ch == CH_SEMI) begin
                    if (r_i == '0 || (r_sel != 10'd0 && r_sel != 10'd2)) begin
                        n_state = S_FLUSH;
                    end else begin
                        emit        = 1'b1;
                        e_res.act   = ACT_TITLE;
                        e_res.value = r_cmd.data - 16'(r_i) - 16'd1;
                        n_i         = r_i + 1'b1;
                        n_state     = S_T_EMIT;
                    end
                end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    n_sel = (sel_next > 14'd1000) ? 10'd1000 : sel_next[9:0];
                    n_i   = r_i + 1'b1;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_T_EMIT: begin
                if (16'(r_i) >= r_cmd.data) begin
                    n_state = S_FLUSH;
                end else begin
                    emit        = 1'b1;
                    e_res.act   = ACT_TITLE_CH;
                    e_res.value = {8'd0, ch};
                    n_i         = r_i + 1'b1;
                end
            end
            S_FLUSH: begin
                // Release the held action as the final one of this byte
                o_res      = '{act: r_pend.act, value: r_pend.value, arg_a: r_pend.arg_a,
                               arg_b: r_pend.arg_b, last: 1'b1};
                o_res_push = r_pend_v;
                go         = !(r_pend_v && i_res_full);
                o_done     = go;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Push the previously held action when a new one arrives
        if (emit && r_pend_v) begin
            o_res_push = 1'b1;
            go         = !i_res_full;
        end
    end

    always_comb begin
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        if (emit) begin
            n_pend   = e_res;
            n_pend_v = 1'b1;
        end else if (r_state == S_FLUSH) begin
            n_pend_v = 1'b0;
        end
    end

    // Advance when the result queue can take what this step pushes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
        end else if (go) begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_cmd  <= n_cmd;
            r_i    <= n_i;
            r_a0   <= n_a0;
            r_base <= n_base;
            r_r    <= n_r;
            r_g    <= n_g;
            r_sel  <= n_sel;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== rtl/terminal_escape_sequence_parser.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_sequence_parser
// Terminal byte stream to terminal action stream, with front/back split.
// ----------------------------------------------------------------------------
// Bytes are pushed one at a time and actions are popped from a result queue;
// each action carries last on the final action caused by its byte. A plain
// byte (text or a known control byte) is taken while full is low, and its
// action passes through the command queue and then the result queue. A CSI
// final byte or a title terminator hands the sequence to the executor, which
// reads the parameter or title store one entry per cycle while the result
// queue has room. While such a sequence executes, full stays high.
// screen_rows resets to 24 and is written through the cfg channel, which is
// always ready.
module terminal_escape_sequence_parser
    import tesp_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int OSC_BYTES  = OSC_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_in,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_action,
    output logic [15:0] o_value,
    output logic [15:0] o_arg_a,
    output logic [7:0]  o_arg_b,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    localparam int PIW = $clog2(MAX_PARAMS);
    localparam int OIW = $clog2(OSC_BYTES);

    logic [15:0]    r_screen_rows;
    t_cmd           front_cmd;
    logic           front_push;
    logic [$bits(t_cmd)-1:0] q_data;
    t_cmd           back_cmd;
    logic           cmdq_full;
    logic           cmdq_empty;
    logic           cmd_pop;
    logic           done;
    logic [PIW-1:0] prd_idx;
    logic [16:0]    prd_data;
    logic [OIW-1:0] ord_idx;
    logic [7:0]     ord_data;
    t_result        res;
    logic           res_push;
    logic           res_full;
    t_result        out_res;
    logic [$bits(t_result)-1:0] out_data;

    // Hold the screen height register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_rows <= 16'd24;
        end else if (i_cfg_valid) begin
            r_screen_rows <= i_cfg_data;
        end
    end

    tesp_front #(
        .MAX_PARAMS (MAX_PARAMS),
        .OSC_BYTES  (OSC_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_byte_in   (i_byte_in),
        .o_full      (full),
        .o_cmd       (front_cmd),
        .o_cmd_push  (front_push),
        .i_cmdq_full (cmdq_full),
        .i_done      (done),
        .i_prd_idx   (prd_idx),
        .o_prd_data  (prd_data),
        .i_ord_idx   (ord_idx),
        .o_ord_data  (ord_data)
    );

    tesp_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_data  (q_data),
        .o_empty (cmdq_empty)
    );

    assign back_cmd = t_cmd'(q_data);

    tesp_back #(
        .MAX_PARAMS (MAX_PARAMS),
        .OSC_BYTES  (OSC_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (back_cmd),
        .i_cmd_valid   (!cmdq_empty),
        .o_cmd_pop     (cmd_pop),
        .i_screen_rows (r_screen_rows),
        .o_prd_idx     (prd_idx),
        .i_prd_data    (prd_data),
        .o_ord_idx     (ord_idx),
        .i_ord_data    (ord_data),
        .o_res         (res),
        .o_res_push    (res_push),
        .i_res_full    (res_full),
        .o_done        (done)
    );

    tesp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign out_res  = t_result'(out_data);
    assign o_action = out_res.act;
    assign o_value  = out_res.value;
    assign o_arg_a  = out_res.arg_a;
    assign o_arg_b  = out_res.arg_b;
    assign o_last   = out_res.last;

endmodule

// ===== rtl/tesp_checker.sv =====
// ----------------------------------------------------------------------------
// tesp_checker
// Port-level checks of the terminal escape sequence parser.
// ----------------------------------------------------------------------------
module tesp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_byte_in,
    input logic        empty,
    input logic        pop,
    input logic [4:0]  o_action,
    input logic [15:0] o_value,
    input logic [15:0] o_arg_a,
    input logic [7:0]  o_arg_b,
    input logic        o_last,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [15:0] i_cfg_data
);
    import tesp_pkg::*;

    // Result queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Only defined action codes come out
    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_action <= ACT_MAX)
        else $error("undefined action code");

    // Blue component only on RGB colour actions
    a_blue_rgb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_arg_b != 8'd0) |->
        (o_action == ACT_FG_RGB || o_action == ACT_FG_RGB + 5'd1))
        else $error("blue component on a non-RGB action");

    // A printed byte is always the only action of its byte
    a_print_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_action == ACT_PRINT) |-> o_last)
        else $error("print action without last");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_action) && $stable(o_value)))
        else $error("waiting result changed");

endmodule

bind terminal_escape_sequence_parser tesp_checker u_tesp_checker (.*);
